FILE: src/icl_pkg.sv
// ----------------------------------------------------------------------------
// Implication closure engine package
// Shared codes, defaults and the token control word that moves along the
// chain of implication cells.
// ----------------------------------------------------------------------------
package icl_pkg;

  // Default sizes of the sets and of the implication table.
  localparam int SetBitsDef = 64;
  localparam int EntriesDef = 64;

  // Item kinds carried in tuser.
  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_CLOSURE = 2'd1;
  localparam logic [1:0] KIND_NEXT    = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // Control word of a token. The flag means "set changed" for a closure
  // token and "premise found" for an insert token.
  typedef struct packed {
    logic valid;
    logic ins;
    logic flag;
  } tok_ctl_t;

endpackage

FILE: src/icl_cell.sv
// ----------------------------------------------------------------------------
// Implication cell
// Holds one premise and conclusion. Each token is registered on its way through:
// closure tokens pick up the conclusion, insert tokens overwrite it on a
// matching premise.
// ----------------------------------------------------------------------------
module icl_cell import icl_pkg::*; #(
  parameter int SET_BITS = SetBitsDef,
  parameter int ENTRIES  = EntriesDef,
  parameter int IDX      = 0,
  localparam int IW = $clog2(ENTRIES),
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CW-1:0]       count,
  input  tok_ctl_t            in_ctl,
  input  logic [SET_BITS-1:0] in_set,
  input  logic [SET_BITS-1:0] in_conc,
  output tok_ctl_t            out_ctl,
  output logic [SET_BITS-1:0] out_set,
  output logic [SET_BITS-1:0] out_conc,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_idx,
  input  logic [SET_BITS-1:0] wr_prem,
  input  logic [SET_BITS-1:0] wr_conc
);

  logic [SET_BITS-1:0] prem;
  logic [SET_BITS-1:0] conc;
  logic                live;
  logic                hit_sub;
  logic                hit_eq;
  tok_ctl_t            ctl_next;
  logic [SET_BITS-1:0] set_next;

  assign live    = (CW'(IDX) < count);
  assign hit_sub = ((prem & ~in_set) == '0);
  assign hit_eq  = (prem == in_set);

  // Token update as it passes this entry.
  always_comb begin
    ctl_next = in_ctl;
    set_next = in_set;
    if (in_ctl.valid && live) begin
      if (in_ctl.ins) begin
        if (hit_eq) begin
          ctl_next.flag = 1'b1;
        end
      end else if (hit_sub) begin
        set_next = in_set | conc;
        if ((conc & ~in_set) != '0) begin
          ctl_next.flag = 1'b1;
        end
      end
    end
  end

  // Token stage toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= ctl_next;
    end
    out_set  <= set_next;
    out_conc <= in_conc;
  end

  // Entry storage: append write from the controller or in-place overwrite.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IW'(IDX))) begin
      prem <= wr_prem;
      conc <= wr_conc;
    end else if (in_ctl.valid && in_ctl.ins && live && hit_eq) begin
      conc <= in_conc;
    end
  end

endmodule

FILE: src/implication_closure_engine.sv
// ----------------------------------------------------------------------------
// Implication closure engine
// Table of attribute implications in a chain of cells with insert, closure
// and next pseudo-intent queries.
// ----------------------------------------------------------------------------
// Insert makes one pass of the chain; a closure makes passes of the chain until
// a pass adds no attribute, then the result goes to the output; a next query
// runs up to attr_count closures, trying or skipping one attribute at a time
// from the top down.
// One item is worked on at a time; a new item is taken only in the idle state.
// Reset (rst, synchronous) empties the table and sets attr_count to 63.
// ----------------------------------------------------------------------------
module implication_closure_engine import icl_pkg::*; #(
  parameter int SET_BITS = SetBitsDef,
  parameter int ENTRIES  = EntriesDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // set_a [63:0], set_b [127:64]
  input  logic [1:0]   s_tuser,   // kind [1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // result_set [63:0]
  output logic [1:0]   m_tuser,   // status [1:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data   // attr_count [5:0]
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int BW = $clog2(SET_BITS);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_SCAN, S_DONE} state_t;

  state_t              state;
  logic [1:0]          kind_r;
  logic [SET_BITS-1:0] a_r;
  logic [SET_BITS-1:0] b_r;
  logic [BW-1:0]       bit_i;
  logic [CW-1:0]       count;
  logic [5:0]          attr;
  logic [SET_BITS-1:0] res_r;
  logic [1:0]          st_r;
  logic                wr_en;
  logic [IW-1:0]       wr_idx;

  tok_ctl_t            tok_ctl  [ENTRIES+1];
  logic [SET_BITS-1:0] tok_set  [ENTRIES+1];
  logic [SET_BITS-1:0] tok_conc [ENTRIES+1];

  logic [SET_BITS-1:0] in_a;
  logic [SET_BITS-1:0] in_b;
  logic [6:0]          n_wide;
  logic [BW-1:0]       n_top;
  logic [SET_BITS-1:0] cand;
  logic [SET_BITS-1:0] below;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_a      = s_tdata[SET_BITS-1:0];
  assign in_b      = s_tdata[64+SET_BITS-1:64];

  // Highest attribute scanned, limited to the set width.
  assign n_wide = (7'(attr) > 7'(SET_BITS - 1)) ? 7'(SET_BITS - 1) : 7'(attr);
  assign n_top  = n_wide[BW-1:0];

  // Candidate for the current attribute: clear bits above it up to the top,
  // set the attribute itself.
  always_comb begin
    for (int k = 0; k < SET_BITS; k++) begin
      below[k] = (k < int'(bit_i));
      if (k == int'(bit_i)) begin
        cand[k] = 1'b1;
      end else if ((k > int'(bit_i)) && (k <= int'(n_top))) begin
        cand[k] = 1'b0;
      end else begin
        cand[k] = a_r[k];
      end
    end
  end

  // Chain of implication cells.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    icl_cell #(
      .SET_BITS (SET_BITS),
      .ENTRIES  (ENTRIES),
      .IDX      (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .count    (count),
      .in_ctl   (tok_ctl[g]),
      .in_set   (tok_set[g]),
      .in_conc  (tok_conc[g]),
      .out_ctl  (tok_ctl[g+1]),
      .out_set  (tok_set[g+1]),
      .out_conc (tok_conc[g+1]),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_prem  (a_r),
      .wr_conc  (b_r)
    );
  end

  // Sequencer, token launch, table count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      attr        <= 6'd63;
      wr_en       <= 1'b0;
      m_tvalid    <= 1'b0;
      tok_ctl[0]  <= '0;
    end else begin
      wr_en      <= 1'b0;
      tok_ctl[0] <= '0;
      if (cfg_valid && cfg_ready) begin
        attr <= cfg_data;
      end
      // A waiting result leaves unless a new one replaces it below.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            kind_r <= s_tuser;
            a_r    <= in_a;
            b_r    <= in_b & ~in_a;
            case (s_tuser)
              KIND_INSERT: begin
                if (in_a == in_b) begin
                  res_r <= '0;
                  st_r  <= ST_OK;
                  state <= S_DONE;
                end else begin
                  tok_ctl[0]  <= '{valid: 1'b1, ins: 1'b1, flag: 1'b0};
                  tok_set[0]  <= in_a;
                  tok_conc[0] <= in_b & ~in_a;
                  state       <= S_RUN;
                end
              end
              KIND_CLOSURE: begin
                tok_ctl[0] <= '{valid: 1'b1, ins: 1'b0, flag: 1'b0};
                tok_set[0] <= in_a;
                state      <= S_RUN;
              end
              KIND_NEXT: begin
                bit_i <= n_top;
                state <= S_SCAN;
              end
              default: begin
                res_r <= '0;
                st_r  <= ST_OK;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (bit_i == '0) begin
            res_r <= '0;
            st_r  <= ST_NONE;
            state <= S_DONE;
          end else if (a_r[bit_i]) begin
            bit_i <= bit_i - 1'b1;
          end else begin
            tok_ctl[0] <= '{valid: 1'b1, ins: 1'b0, flag: 1'b0};
            tok_set[0] <= cand;
            state      <= S_RUN;
          end
        end
        S_RUN: begin
          if (tok_ctl[ENTRIES].valid) begin
            if (tok_ctl[ENTRIES].ins) begin
              res_r <= '0;
              state <= S_DONE;
              if (tok_ctl[ENTRIES].flag) begin
                st_r <= ST_OK;
              end else if (count == CW'(ENTRIES)) begin
                st_r <= ST_FULL;
              end else begin
                st_r   <= ST_OK;
                wr_en  <= 1'b1;
                wr_idx <= count[IW-1:0];
                count  <= count + 1'b1;
              end
            end else if (tok_ctl[ENTRIES].flag) begin
              // Something was added this pass: go around again.
              tok_ctl[0] <= '{valid: 1'b1, ins: 1'b0, flag: 1'b0};
              tok_set[0] <= tok_set[ENTRIES];
            end else if (kind_r == KIND_NEXT) begin
              if (((tok_set[ENTRIES] ^ a_r) & below) == '0) begin
                res_r <= tok_set[ENTRIES];
                st_r  <= ST_OK;
                state <= S_DONE;
              end else begin
                bit_i <= bit_i - 1'b1;
                state <= S_SCAN;
              end
            end else begin
              res_r <= tok_set[ENTRIES];
              st_r  <= ST_OK;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= 64'(res_r);
            m_tuser  <= st_r;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
